// File: hw/rtl/dnd_pkg.sv
// Shared types, constants and helper functions of the DNS name decompressor.
package dnd_pkg;

	localparam int PACKET_BYTES_DEF = 512;
	localparam int TEXT_BYTES_DEF   = 1024;
	localparam int MAX_POINTERS_DEF = 10;

	localparam int OFF_W  = 15;   // walk offset, holds a 14-bit pointer target plus carry
	localparam int NOFF_W = 13;   // text write position and budget

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_PARSE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_BSL  = 8'h5c;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOW  = 8'h20;
	localparam logic [7:0] CH_HIGH = 8'h7e;

	localparam logic [1:0] LBL_PLAIN = 2'b00;
	localparam logic [1:0] LBL_PTR   = 2'b11;

	localparam logic [NOFF_W-1:0] BUDGET_START = NOFF_W'(255);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_LOAD,
		OP_RD_TEXT,
		OP_CAP_TEXT,
		OP_INIT,
		OP_RD_PKT,
		OP_HDR,
		OP_DOT,
		OP_CHAR,
		OP_ESC,
		OP_PTR,
		OP_FINISH,
		OP_FAIL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic off_over;
		logic hdr_zero;
		logic hdr_label;
		logic hdr_ptr;
		logic body_over;
		logic cnt_zero;
		logic char_fail;
		logic char_plain;
		logic esc_last;
		logic ptr_ok;
		logic ptr_max;
	} dp_stat_t;

	function automatic logic is_special(input logic [7:0] b);
		return b == 8'h2e || b == 8'h28 || b == 8'h29 || b == 8'h3b ||
		       b == 8'h20 || b == 8'h40 || b == 8'h22 || b == 8'h5c;
	endfunction

	// Three ASCII decimal digits, hundreds in the top byte; reciprocal multiplies.
	function automatic logic [23:0] dec_digits(input logic [7:0] b);
		logic [13:0] ph;
		logic [1:0]  h;
		logic [7:0]  rem;
		logic [14:0] pt;
		logic [3:0]  t;
		logic [7:0]  o;
		ph  = 14'(b) * 14'd41;
		h   = ph[13:12];
		rem = b - 8'(h) * 8'd100;
		pt  = 15'(rem) * 15'd205;
		t   = pt[14:11];
		o   = rem - 8'(t) * 8'd10;
		return {CH_ZERO + 8'(h), CH_ZERO + 8'(t), CH_ZERO + o};
	endfunction

endpackage

// File: hw/rtl/dnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/dnd_dp.sv
// Datapath: packet and text stores, walk registers, escape buffer and result registers.
module dnd_dp import dnd_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int TEXT_BYTES   = TEXT_BYTES_DEF,
	parameter int MAX_POINTERS = MAX_POINTERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic [8:0] packet_addr,
	input  logic [7:0] byte_value,
	input  logic [8:0] start_offset,
	input  logic [9:0] span_len,
	input  logic [9:0] packet_len,
	input  logic       pointers_allowed,
	input  logic [9:0] text_index,
	output logic [9:0] name_length,
	output logic [9:0] consumed,
	output logic       parse_error,
	output logic [7:0] text_char
);

	localparam int PA_W  = $clog2(PACKET_BYTES);
	localparam int TA_W  = $clog2(TEXT_BYTES);
	localparam int PTR_W = $clog2(MAX_POINTERS + 1);

	// latched item fields
	logic [8:0]  paddr_q;
	logic [7:0]  pbyte_q;
	logic [8:0]  start_q;
	logic [9:0]  dlen_q;
	logic [9:0]  plen_q;
	logic        pok_q;
	logic [9:0]  tidx_q;

	// walk state
	logic [8:0]        base_q;
	logic [OFF_W-1:0]  off_q;
	logic [9:0]        limit_q;
	logic [NOFF_W-1:0] noff_q;
	logic [NOFF_W-1:0] budget_q;
	logic [PTR_W-1:0]  ptrs_q;
	logic [OFF_W-1:0]  res_q;
	logic [7:0]        hdr_q;
	logic [5:0]        cnt_q;
	logic [2:0][7:0]   esc_q;
	logic [1:0]        esc_n_q;

	// text store bank that holds the committed name
	logic       bank_q;
	logic [9:0] tlen_q;
	logic [9:0] cons_q;
	logic       err_q;
	logic [7:0] char_q;

	logic [7:0]         pkt_rdata;
	logic [7:0]         txt_rdata;
	logic [16:0]        psum;
	logic [15:0]        pwaddr_ext;
	logic [NOFF_W-1:0]  twpos;
	logic [11:0]        tidx_ext;
	logic               t_we;
	logic [7:0]         t_wdata;
	logic [TA_W:0]      t_waddr;
	logic [TA_W:0]      t_raddr;
	logic               special;
	logic               nonprint;
	logic [NOFF_W-1:0]  need;
	logic [NOFF_W-1:0]  noff_fin;
	logic               fin_fail;
	logic [OFF_W:0]     body_end;

	assign psum       = {8'b0, base_q} + {2'b0, off_q};
	assign pwaddr_ext = {7'b0, paddr_q};
	assign tidx_ext   = {2'b0, tidx_q};

	dnd_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
		.clk   (clk),
		.we    (cmd.op == OP_LOAD),
		.waddr (pwaddr_ext[PA_W-1:0]),
		.wdata (pbyte_q),
		.raddr (psum[PA_W-1:0]),
		.rdata (pkt_rdata)
	);

	// new text goes to the idle bank; it becomes visible only on a clean finish
	assign twpos   = (cmd.op == OP_FINISH) ? '0 : noff_q;
	assign t_waddr = {~bank_q, twpos[TA_W-1:0]};
	assign t_raddr = {bank_q, tidx_ext[TA_W-1:0]};

	always_comb begin
		t_we    = 1'b0;
		t_wdata = CH_DOT;
		case (cmd.op)
			OP_DOT: begin
				t_we = 1'b1;
			end
			OP_CHAR: begin
				t_we    = 1'b1;
				t_wdata = (special || nonprint) ? CH_BSL : pkt_rdata;
			end
			OP_ESC: begin
				t_we    = 1'b1;
				t_wdata = esc_q[0];
			end
			OP_FINISH: begin
				t_we = (noff_q == '0);
			end
			default: begin
				t_we = 1'b0;
			end
		endcase
	end

	dnd_ram #(.WIDTH(8), .DEPTH(2 * TEXT_BYTES)) u_txt_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (txt_rdata)
	);

	assign special  = is_special(pkt_rdata);
	assign nonprint = (pkt_rdata < CH_LOW) || (pkt_rdata > CH_HIGH);
	assign need     = special ? NOFF_W'(2) : (nonprint ? NOFF_W'(4) : NOFF_W'(1));
	assign noff_fin = (noff_q == '0) ? NOFF_W'(1) : noff_q;
	assign fin_fail = noff_fin >= budget_q;
	assign body_end = {1'b0, off_q} + (OFF_W + 1)'(pkt_rdata[5:0]);

	always_comb begin
		stat.off_over   = off_q >= OFF_W'(limit_q);
		stat.hdr_zero   = pkt_rdata == 8'd0;
		stat.hdr_label  = pkt_rdata[7:6] == LBL_PLAIN;
		stat.hdr_ptr    = pkt_rdata[7:6] == LBL_PTR;
		stat.body_over  = body_end > (OFF_W + 1)'(limit_q);
		stat.cnt_zero   = cnt_q == '0;
		stat.char_fail  = (noff_q + need) >= budget_q;
		stat.char_plain = !special && !nonprint;
		stat.esc_last   = esc_n_q == 2'd1;
		stat.ptr_ok     = pok_q;
		stat.ptr_max    = ptrs_q == PTR_W'(MAX_POINTERS);
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				paddr_q <= packet_addr;
				pbyte_q <= byte_value;
				start_q <= start_offset;
				dlen_q  <= span_len;
				plen_q  <= packet_len;
				pok_q   <= pointers_allowed;
				tidx_q  <= text_index;
			end
			OP_INIT: begin
				base_q   <= start_q;
				off_q    <= '0;
				limit_q  <= dlen_q;
				noff_q   <= '0;
				budget_q <= BUDGET_START;
				ptrs_q   <= '0;
				res_q    <= '0;
			end
			OP_RD_PKT: begin
				off_q <= off_q + OFF_W'(1);
				cnt_q <= cnt_q - 6'd1;
			end
			OP_HDR: begin
				hdr_q <= pkt_rdata;
				cnt_q <= pkt_rdata[5:0];
			end
			OP_DOT: begin
				noff_q <= noff_q + NOFF_W'(1);
			end
			OP_CHAR: begin
				noff_q <= noff_q + NOFF_W'(1);
				if (special) begin
					esc_q[0] <= pkt_rdata;
					esc_n_q  <= 2'd1;
					budget_q <= budget_q + NOFF_W'(1);
				end else if (nonprint) begin
					{esc_q[0], esc_q[1], esc_q[2]} <= dec_digits(pkt_rdata);
					esc_n_q  <= 2'd3;
					budget_q <= budget_q + NOFF_W'(3);
				end
			end
			OP_ESC: begin
				noff_q   <= noff_q + NOFF_W'(1);
				esc_q[0] <= esc_q[1];
				esc_q[1] <= esc_q[2];
				esc_n_q  <= esc_n_q - 2'd1;
			end
			OP_PTR: begin
				if (ptrs_q == '0) begin
					res_q <= off_q;
				end
				ptrs_q  <= ptrs_q + PTR_W'(1);
				off_q   <= OFF_W'({hdr_q[5:0], pkt_rdata});
				base_q  <= '0;
				limit_q <= plen_q;
			end
			default: begin
			end
		endcase
	end

	// committed text and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			tlen_q <= '0;
			cons_q <= '0;
			err_q  <= 1'b0;
			char_q <= '0;
		end else begin
			case (cmd.op)
				OP_LATCH: begin
					cons_q <= '0;
					err_q  <= 1'b0;
					char_q <= '0;
				end
				OP_CAP_TEXT: begin
					char_q <= (tidx_q < tlen_q) ? txt_rdata : 8'd0;
				end
				OP_FINISH: begin
					if (fin_fail) begin
						err_q <= 1'b1;
					end else begin
						bank_q <= ~bank_q;
						tlen_q <= noff_fin[9:0];
						cons_q <= (ptrs_q == '0) ? off_q[9:0] : res_q[9:0];
					end
				end
				OP_FAIL: begin
					err_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign name_length = tlen_q;
	assign consumed    = cons_q;
	assign parse_error = err_q;
	assign text_char   = char_q;

endmodule

// File: hw/rtl/dnd_ctrl.sv
// Controller: sequences loads, text reads and the name walk; owns the handshakes.
module dnd_ctrl import dnd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd,
	input  dp_stat_t   stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RD_ADDR,
		ST_RD_CAP,
		ST_INIT,
		ST_HDR,
		ST_HDR_W,
		ST_BODY,
		ST_BODY_W,
		ST_ESC,
		ST_PTR,
		ST_PTR_W,
		ST_FINISH,
		ST_FAIL,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = OP_LATCH;
					case (action)
						ACT_LOAD:  state_d = ST_LOAD;
						ACT_PARSE: state_d = ST_INIT;
						ACT_READ:  state_d = ST_RD_ADDR;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.op  = OP_LOAD;
				state_d = ST_DONE;
			end
			ST_RD_ADDR: begin
				cmd.op  = OP_RD_TEXT;
				state_d = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				cmd.op  = OP_CAP_TEXT;
				state_d = ST_DONE;
			end
			ST_INIT: begin
				cmd.op  = OP_INIT;
				state_d = ST_HDR;
			end
			ST_HDR: begin
				if (stat.off_over) begin
					state_d = ST_FAIL;
				end else begin
					cmd.op  = OP_RD_PKT;
					state_d = ST_HDR_W;
				end
			end
			ST_HDR_W: begin
				cmd.op = OP_HDR;
				if (stat.hdr_zero) begin
					state_d = ST_FINISH;
				end else if (stat.hdr_label) begin
					state_d = stat.body_over ? ST_FAIL : ST_BODY;
				end else if (stat.hdr_ptr && stat.ptr_ok) begin
					state_d = ST_PTR;
				end else begin
					state_d = ST_FAIL;
				end
			end
			ST_BODY: begin
				if (stat.cnt_zero) begin
					cmd.op  = OP_DOT;
					state_d = ST_HDR;
				end else begin
					cmd.op  = OP_RD_PKT;
					state_d = ST_BODY_W;
				end
			end
			ST_BODY_W: begin
				if (stat.char_fail) begin
					state_d = ST_FAIL;
				end else begin
					cmd.op  = OP_CHAR;
					state_d = stat.char_plain ? ST_BODY : ST_ESC;
				end
			end
			ST_ESC: begin
				cmd.op  = OP_ESC;
				state_d = stat.esc_last ? ST_BODY : ST_ESC;
			end
			ST_PTR: begin
				if (stat.off_over) begin
					state_d = ST_FAIL;
				end else begin
					cmd.op  = OP_RD_PKT;
					state_d = ST_PTR_W;
				end
			end
			ST_PTR_W: begin
				if (stat.ptr_max) begin
					state_d = ST_FAIL;
				end else begin
					cmd.op  = OP_PTR;
					state_d = ST_HDR;
				end
			end
			ST_FINISH: begin
				cmd.op  = OP_FINISH;
				state_d = ST_DONE;
			end
			ST_FAIL: begin
				cmd.op  = OP_FAIL;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/dns_name_decompress_escape_top.sv
// Top level of the DNS name decompressor with presentation escaping.
//
// One input channel and one output channel, both valid/ready. Each accepted
// item gives exactly one result item; results come back in order.
//  action 0 writes byte_value into the packet store at packet_addr.
//  action 1 walks the wire-format name at start_offset, following compression
//    pointers, and writes its escaped text into the text store.
//  action 2 returns the text character at text_index (0 past name_length).
//  action 3 does nothing and answers like a load.
// A parse spends time on each wire byte (headers, body bytes and pointer
// bytes), on each label dot and on each extra escape character. Text is
// written one character at a time. The longest parse is of about 250
// bytes that each need a four-character escape.
// One item is in flight at a time: in_ready drops from acceptance until the
// result has been taken. A stalled receiver holds the result and the block.
// Reset clears the name length and results; both stores hold garbage until
// written. A failed parse leaves the stored text and its length unchanged.
module dns_name_decompress_escape_top import dnd_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int TEXT_BYTES   = TEXT_BYTES_DEF,
	parameter int MAX_POINTERS = MAX_POINTERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [8:0] packet_addr,
	input  logic [7:0] byte_value,
	input  logic [8:0] start_offset,
	input  logic [9:0] span_len,
	input  logic [9:0] packet_len,
	input  logic       pointers_allowed,
	input  logic [9:0] text_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [9:0] name_length,
	output logic [9:0] consumed,
	output logic       parse_error,
	output logic [7:0] text_char
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dnd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	dnd_dp #(
		.PACKET_BYTES (PACKET_BYTES),
		.TEXT_BYTES   (TEXT_BYTES),
		.MAX_POINTERS (MAX_POINTERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.packet_addr      (packet_addr),
		.byte_value       (byte_value),
		.start_offset     (start_offset),
		.span_len         (span_len),
		.packet_len       (packet_len),
		.pointers_allowed (pointers_allowed),
		.text_index       (text_index),
		.name_length      (name_length),
		.consumed         (consumed),
		.parse_error      (parse_error),
		.text_char        (text_char)
	);

endmodule

// File: sim/dns_name_decompress_escape_top_tb.sv
// Testbench for the DNS name decompressor: directed name cases, random names, stalls.
`timescale 1ns / 1ps

module dns_name_decompress_escape_top_tb;
	import dnd_pkg::*;

	localparam logic [1:0] ACT_IDLE = 2'd3;
	localparam int PKT_N = 512;
	localparam int TXT_N = 1024;
	localparam int MAX_PTRS = 10;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 10000;

	typedef struct {
		logic [9:0] name_length;
		logic [9:0] consumed;
		logic       parse_error;
		logic [7:0] text_char;
	} answer_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_ready;
	logic [1:0] action = ACT_LOAD;
	logic [8:0] packet_addr = '0;
	logic [7:0] byte_value = '0;
	logic [8:0] start_offset = '0;
	logic [9:0] span_len = '0;
	logic [9:0] packet_len = '0;
	logic       pointers_allowed = 0;
	logic [9:0] text_index = '0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [9:0] name_length;
	logic [9:0] consumed;
	logic       parse_error;
	logic [7:0] text_char;

	dns_name_decompress_escape_top DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [7:0] pkt_mem [PKT_N];
	logic [7:0] txt_mem [TXT_N];
	logic [7:0] scratch [TXT_N];
	int         txt_len;

	answer_t answers_due [$];
	int      errors = 0;
	int      n_results = 0;
	int      n_items, n_parse_ok, n_parse_err, n_reads;
	bit      no_idle;
	logic    hold_req = 0;
	logic    hold_seen = 0;
	int      stall_cnt = 0;
	int      quiet_cycles = 0;
	int      name_starts [$];

	function automatic bit is_special_char(input logic [7:0] b);
		return b == 8'h2e || b == 8'h28 || b == 8'h29 || b == 8'h3b ||
		       b == 8'h20 || b == 8'h40 || b == 8'h22 || b == 8'h5c;
	endfunction

	function automatic bit walk_name(input int start, input int dlen, input int plen,
			input bit pok, output int len, output int used);
		int base, limit, off, noff, budget, ptrs, res, j;
		logic [7:0] c, c1, b;
		base = start; limit = dlen; off = 0; noff = 0;
		budget = 255; ptrs = 0; res = 0; len = 0; used = 0;
		for (int k = 0; k < TXT_N; k++) scratch[k] = txt_mem[k];
		forever begin
			if (off >= limit) return 0;
			c = pkt_mem[(base + off) % PKT_N];
			off++;
			if (c == 0) break;
			if (c[7:6] == 2'b00) begin
				if (off + c > limit) return 0;
				for (j = off; j < off + c; j++) begin
					b = pkt_mem[(base + j) % PKT_N];
					if (is_special_char(b)) begin
						if (noff + 2 >= budget) return 0;
						scratch[noff % TXT_N] = 8'h5c;
						scratch[(noff + 1) % TXT_N] = b;
						noff += 2; budget += 1;
					end else if (b < 8'h20 || b > 8'h7e) begin
						if (noff + 4 >= budget) return 0;
						scratch[noff % TXT_N] = 8'h5c;
						scratch[(noff + 1) % TXT_N] = 8'h30 + b / 100;
						scratch[(noff + 2) % TXT_N] = 8'h30 + (b / 10) % 10;
						scratch[(noff + 3) % TXT_N] = 8'h30 + b % 10;
						noff += 4; budget += 3;
					end else begin
						if (noff + 1 >= budget) return 0;
						scratch[noff % TXT_N] = b;
						noff += 1;
					end
				end
				scratch[noff % TXT_N] = 8'h2e;
				noff += 1;
				off += c;
			end else if (c[7:6] == 2'b11) begin
				if (!pok) return 0;
				if (off >= limit) return 0;
				c1 = pkt_mem[(base + off) % PKT_N];
				off++;
				if (ptrs == 0) res = off;
				ptrs++;
				if (ptrs > MAX_PTRS) return 0;
				off = {c[5:0], c1};
				base = 0;
				limit = plen;
			end else begin
				return 0;
			end
		end
		if (ptrs == 0) res = off;
		if (noff == 0) begin
			scratch[0] = 8'h2e;
			noff = 1;
		end
		if (noff >= budget) return 0;
		len = noff;
		used = res;
		return 1;
	endfunction

	// Applies one accepted item to the predictor and returns its answer.
	function automatic answer_t predict_answer(input logic [1:0] act, input logic [8:0] addr,
			input logic [7:0] bval, input logic [8:0] so, input logic [9:0] dl,
			input logic [9:0] pl, input logic pa, input logic [9:0] ti);
		answer_t a;
		int len, used;
		a.consumed = 0; a.parse_error = 0; a.text_char = 0;
		if (act == ACT_LOAD) begin
			pkt_mem[addr] = bval;
		end else if (act == ACT_PARSE) begin
			if (walk_name(so, dl, pl, pa, len, used)) begin
				for (int k = 0; k < TXT_N; k++) txt_mem[k] = scratch[k];
				txt_len = len & 10'h3ff;
				a.consumed = used[9:0];
				n_parse_ok++;
			end else begin
				a.parse_error = 1;
				n_parse_err++;
			end
		end else if (act == ACT_READ) begin
			if (ti < txt_len) a.text_char = txt_mem[ti];
			n_reads++;
		end
		a.name_length = txt_len[9:0];
		return a;
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [8:0] addr = 0,
			input logic [7:0] bval = 0, input logic [8:0] so = 0,
			input logic [9:0] dl = 512, input logic [9:0] pl = 512,
			input logic pa = 1, input logic [9:0] ti = 0);
		int gap;
		action <= act; packet_addr <= addr; byte_value <= bval;
		start_offset <= so; span_len <= dl; packet_len <= pl;
		pointers_allowed <= pa; text_index <= ti;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		answers_due.push_back(predict_answer(act, addr, bval, so, dl, pl, pa, ti));
		n_items++;
		if (!no_idle && $urandom_range(99) < 32) begin
			in_valid <= 0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic parse_name(input int so, input int dl = 512, input int pl = 512,
			input bit pa = 1);
		send_item(ACT_PARSE, 0, 0, so[8:0], dl[9:0], pl[9:0], pa);
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t e;
		if (out_valid && out_ready) begin
			n_results++;
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result len=%0d cons=%0d err=%0d ch=%h", $time,
					name_length, consumed, parse_error, text_char);
				errors++;
			end else begin
				e = answers_due.pop_front();
				if (name_length !== e.name_length) begin
					$display("%0t: name_length expected %0d actual %0d", $time,
						e.name_length, name_length);
					errors++;
				end
				if (consumed !== e.consumed) begin
					$display("%0t: consumed expected %0d actual %0d", $time,
						e.consumed, consumed);
					errors++;
				end
				if (parse_error !== e.parse_error) begin
					$display("%0t: parse_error expected %0d actual %0d", $time,
						e.parse_error, parse_error);
					errors++;
				end
				if (text_char !== e.text_char) begin
					$display("%0t: text_char expected %h actual %h", $time,
						e.text_char, text_char);
					errors++;
				end
			end
		end
	end

	// receiver: random backpressure plus one long hold on request
	always @(posedge clk) begin
		if (hold_req && !hold_seen) begin
			hold_seen <= 1;
			stall_cnt = HOLD_CYCLES;
		end
		if (stall_cnt > 0) begin
			stall_cnt--;
			out_ready <= 0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 32);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				answers_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Whole packet store is written first so no parse touches an unwritten byte.
	// 256..511 holds four 63-byte labels whose terminator wraps to address 0.
	task automatic test_fill_packet();
		logic [7:0] v;
		for (int a = 0; a < PKT_N; a++) begin
			if (a == 0) v = 8'h00;
			else if (a >= 256 && (a - 256) % 64 == 0) v = 8'd63;
			else if (a >= 256) v = 8'h61 + 8'(a % 26);
			else if (a == 1) v = 8'hff;
			else v = 8'($urandom_range(255));
			send_item(ACT_LOAD, a[8:0], v);
		end
	endtask

	task automatic test_directed();
		// "A.\0<ff>" then terminator at 15
		send_item(ACT_LOAD, 10, 8'd4);
		send_item(ACT_LOAD, 11, 8'h41);
		send_item(ACT_LOAD, 12, 8'h2e);
		send_item(ACT_LOAD, 13, 8'h00);
		send_item(ACT_LOAD, 14, 8'hff);
		send_item(ACT_LOAD, 15, 8'h00);
		send_item(ACT_LOAD, 16, 8'h40);
		send_item(ACT_LOAD, 17, 8'h80);
		send_item(ACT_LOAD, 18, 8'hc0);
		send_item(ACT_LOAD, 19, 8'd10);
		send_item(ACT_LOAD, 20, 8'hc0);
		send_item(ACT_LOAD, 21, 8'd20);
		parse_name(15);                 // empty name
		send_item(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd0);
		parse_name(10);                 // escapes
		send_item(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd4);
		send_item(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd1023);
		parse_name(10, 3);              // body past limit
		parse_name(10, 0);
		parse_name(16);                 // reserved label types
		parse_name(17);
		parse_name(18);                 // pointer, consumed 2
		parse_name(18, 512, 512, 0);    // pointers off
		parse_name(18, 512, 0);         // limit after jump
		parse_name(20);                 // pointer loop
		parse_name(256);                // budget exceeded
		parse_name(320, 512, 512, 0);   // 192 chars, wraps to address 0
		send_item(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd191);
		send_item(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd192);
		send_item(ACT_IDLE, 9'h1ff, 8'hff, 9'h1ff, 10'h3ff, 10'h3ff, 1, 10'h3ff);
	endtask

	// Random short name at a random address; ends in zero or a pointer to an earlier one.
	task automatic write_random_name(output int at, output int span);
		int a, nlab, llen, r;
		logic [7:0] b;
		at = $urandom_range(PKT_N - 1);
		a = at;
		nlab = $urandom_range(0, 3);
		for (int l = 0; l < nlab; l++) begin
			llen = $urandom_range(1, 6);
			send_item(ACT_LOAD, a[8:0], llen[7:0]); a++;
			for (int i = 0; i < llen; i++) begin
				r = $urandom_range(99);
				if (r < 60) b = 8'($urandom_range(8'h21, 8'h7e));
				else if (r < 80) b = 8'h2e;
				else b = 8'($urandom_range(255));
				send_item(ACT_LOAD, a[8:0], b); a++;
			end
		end
		if (name_starts.size() > 0 && $urandom_range(2) == 0) begin
			r = name_starts[$urandom_range(name_starts.size() - 1)];
			send_item(ACT_LOAD, a[8:0], {2'b11, 6'(r >> 8)}); a++;
			send_item(ACT_LOAD, a[8:0], r[7:0]); a++;
		end else begin
			send_item(ACT_LOAD, a[8:0], 8'h00); a++;
		end
		span = a - at;
		name_starts.push_back(at);
	endtask

	task automatic read_random_char();
		int ti;
		if (txt_len > 0 && $urandom_range(3) != 0) ti = $urandom_range(txt_len - 1);
		else ti = $urandom_range(TXT_N - 1);
		send_item(ACT_READ, 0, 0, 0, 0, 0, 0, ti[9:0]);
	endtask

	task automatic test_random(input int until_items);
		int at, span, r, so;
		while (n_items < until_items) begin
			r = $urandom_range(99);
			no_idle = (n_items > until_items - 120);
			if (r < 40) begin
				write_random_name(at, span);
				if ($urandom_range(4) == 0) parse_name(at, $urandom_range(0, span));
				else parse_name(at, 512, $urandom_range(3) == 0 ? $urandom_range(512) : 512,
					$urandom_range(9) != 0);
				repeat ($urandom_range(1, 3)) read_random_char();
			end else if (r < 65 && name_starts.size() > 0) begin
				so = name_starts[$urandom_range(name_starts.size() - 1)];
				parse_name(so, $urandom_range(1) ? 512 : $urandom_range(512),
					$urandom_range(512), 1'($urandom_range(1)));
			end else if (r < 75) begin
				parse_name($urandom_range(511), $urandom_range(1023), $urandom_range(1023),
					1'($urandom_range(1)));
			end else if (r < 80) begin
				send_item(ACT_LOAD, 9'($urandom_range(511)), 8'($urandom_range(255)));
			end else begin
				read_random_char();
			end
		end
		no_idle = 0;
	endtask

	// Receiver holds off while the sender keeps offering items.
	task automatic test_backpressure();
		hold_req <= 1;
		for (int i = 0; i < 6; i++) begin
			parse_name(320);
			read_random_char();
		end
	endtask

	initial begin
		int settle;
		n_items = 0;
		n_parse_ok = 0; n_parse_err = 0; n_reads = 0;
		no_idle = 0; txt_len = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_fill_packet();
		test_directed();
		test_backpressure();
		test_random(950);
		in_valid <= 0;
		while (answers_due.size() != 0) @(posedge clk);
		settle = 0;
		while (settle < 50 && !out_valid) begin
			@(posedge clk);
			settle++;
		end
		repeat (5) @(posedge clk);
		$display("Sent %0d items, checked %0d results: %0d good parses, %0d failed parses,",
			n_items, n_results, n_parse_ok, n_parse_err);
		$display("%0d text reads, with random stalls on both sides and one long hold.",
			n_reads);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
